@@ rtl/qrpm_pkg.sv @@
package qrpm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int GAIN_FRAC = 12;
   localparam int DT_FRAC   = 16;
   localparam int INV_FRAC  = 8;

   localparam int DATA_W    = 24;
   localparam int NUM_IN    = 7;
   localparam int NUM_OUT   = 4;
   localparam int GAIN_W    = 16;
   localparam int GAINS_W   = 3 * GAIN_W;
   localparam int STEP_W    = 16;
   localparam int CSR_IDX_W = 3;

   localparam int ERR_W     = DATA_W + 1;
   localparam int DIFF_W    = ERR_W + 1;
   localparam int PERR_W    = FRAC_BITS + 2;
   localparam int INTEG_W   = 40;
   localparam int DERIV_W   = 42;
   localparam int MUL_A_W   = 24;
   localparam int MUL_B_W   = 27;
   localparam int PROD_W    = MUL_A_W + 1 + MUL_B_W;
   localparam int SPLIT     = 21;
   localparam int ACC_W     = 60;
   localparam int PID_W     = ACC_W - GAIN_FRAC;
   localparam int MIX_W     = 51;

   localparam logic signed [ERR_W:0] UNITY =
      {{(ERR_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'd2097;
   localparam logic [DATA_W-1:0] INV_STEP_RST  = 24'd8000;
   localparam logic [DATA_W-1:0] MOTOR_MIN_RST = 24'd3624141;
   localparam logic [DATA_W-1:0] MOTOR_MAX_RST = 24'd3636592;

   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_GAINS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_GAINS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_GAINS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_STEP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_MIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_MAX   = 3'd6;

   localparam logic [2:0] OP_INT   = 3'd0;
   localparam logic [2:0] OP_DER   = 3'd1;
   localparam logic [2:0] OP_KP    = 3'd2;
   localparam logic [2:0] OP_KI_LO = 3'd3;
   localparam logic [2:0] OP_KI_HI = 3'd4;
   localparam logic [2:0] OP_KD_LO = 3'd5;
   localparam logic [2:0] OP_KD_HI = 3'd6;
   localparam logic [2:0] OP_LAST  = OP_KD_HI;

   localparam logic [1:0] AXIS_ROLL  = 2'd0;
   localparam logic [1:0] AXIS_PITCH = 2'd1;
   localparam logic [1:0] AXIS_YAW   = 2'd2;
   localparam logic [1:0] AXIS_LAST  = AXIS_YAW;

   typedef struct packed {
      logic       load_en;
      logic       err_en;
      logic       mul_en;
      logic       use_en;
      logic       pid_en;
      logic       mix_en;
      logic [1:0] axis;
      logic [2:0] op;
   } cmd_type;

endpackage

@@ rtl/qrpm_ctrl.sv @@
module qrpm_ctrl import qrpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ERR  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_USE  = 3'd3;
   localparam logic [2:0] ST_PID  = 3'd4;
   localparam logic [2:0] ST_MIX  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       mix_fire;

   assign mix_fire   = (state_ff == ST_MIX) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.load_en = (state_ff == ST_IDLE) && req_tvalid;
      cmd.err_en  = (state_ff == ST_ERR);
      cmd.mul_en  = (state_ff == ST_MUL);
      cmd.use_en  = (state_ff == ST_USE);
      cmd.pid_en  = (state_ff == ST_PID);
      cmd.mix_en  = mix_fire;
      cmd.axis    = axis_ff;
      cmd.op      = op_ff;
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_ERR;
               axis_in  = AXIS_ROLL;
            end
         end
         ST_ERR: begin
            state_in = ST_MUL;
            op_in    = OP_INT;
         end
         ST_MUL: state_in = ST_USE;
         ST_USE: begin
            if (op_ff == OP_LAST) begin
               state_in = ST_PID;
            end else begin
               state_in = ST_MUL;
               op_in    = op_ff + 3'd1;
            end
         end
         ST_PID: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_MIX;
            end else begin
               state_in = ST_ERR;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_MIX: begin
            if (mix_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (mix_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_ROLL;
         op_ff        <= OP_INT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_en, cmd.err_en, cmd.mul_en, cmd.use_en, cmd.pid_en, cmd.mix_en}))
      else $error("more than one datapath command");

   a_last_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_USE && op_ff == OP_LAST) |=> (state_ff == ST_PID))
      else $error("last op did not close the axis");

   a_last_axis: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PID && axis_ff == AXIS_LAST) |=> (state_ff == ST_MIX))
      else $error("last axis did not go to mix");

   a_rsp_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MIX))
      else $error("result shown without a mix step");

endmodule

@@ rtl/qrpm_dpath.sv @@
module qrpm_dpath import qrpm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   input  logic [NUM_IN*DATA_W-1:0]    req_tdata,
   input  logic [GAINS_W-1:0]          roll_gains,
   input  logic [GAINS_W-1:0]          pitch_gains,
   input  logic [GAINS_W-1:0]          yaw_gains,
   input  logic [STEP_W-1:0]           step_time,
   input  logic [DATA_W-1:0]           inverse_step_time,
   input  logic [DATA_W-1:0]           motor_min,
   input  logic [DATA_W-1:0]           motor_max,
   output logic [NUM_OUT*DATA_W-1:0]   rsp_data
);

   logic signed [DATA_W-1:0]  rate_ff   [3];
   logic signed [DATA_W-1:0]  target_ff [3];
   logic        [DATA_W-1:0]  thr_ff;
   logic signed [ERR_W-1:0]   prev_ff   [3];
   logic signed [INTEG_W-1:0] integ_ff  [3];
   logic signed [PID_W-1:0]   pid_ff    [3];
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [PERR_W-1:0]  perr_ff;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [NUM_OUT*DATA_W-1:0] rsp_data_ff;

   logic signed [DATA_W-1:0]  rate_sel, target_sel;
   logic signed [ERR_W-1:0]   prev_sel;
   logic signed [INTEG_W-1:0] integ_sel;
   logic [GAINS_W-1:0]        gains_sel;
   logic [GAIN_W-1:0]         kp, ki, kd;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [DIFF_W-1:0]  diff_in;
   logic signed [ERR_W:0]     err_x, perr_x;
   logic [MUL_A_W-1:0]        mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [ACC_W-1:0]   addend;
   logic signed [MIX_W-1:0]   thr_x, roll_x, pitch_x, yaw_x;
   logic signed [MIX_W-1:0]   mix1, mix2, mix3, mix4;

   function automatic logic [DATA_W-1:0] motor_clamp(
      input logic signed [MIX_W-1:0] v,
      input logic [DATA_W-1:0]       lo,
      input logic [DATA_W-1:0]       hi
   );
      logic signed [MIX_W-1:0] lo_x;
      logic signed [MIX_W-1:0] hi_x;
      logic [DATA_W-1:0]       res;
      lo_x = {{(MIX_W-DATA_W){1'b0}}, lo};
      hi_x = {{(MIX_W-DATA_W){1'b0}}, hi};
      if (v < lo_x) begin
         res = lo;
      end else if (v > hi_x) begin
         res = hi;
      end else begin
         res = v[DATA_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      case (cmd.axis)
         AXIS_PITCH: begin
            rate_sel   = rate_ff[1];
            target_sel = target_ff[1];
            prev_sel   = prev_ff[1];
            integ_sel  = integ_ff[1];
            gains_sel  = pitch_gains;
         end
         AXIS_YAW: begin
            rate_sel   = rate_ff[2];
            target_sel = target_ff[2];
            prev_sel   = prev_ff[2];
            integ_sel  = integ_ff[2];
            gains_sel  = yaw_gains;
         end
         default: begin
            rate_sel   = rate_ff[0];
            target_sel = target_ff[0];
            prev_sel   = prev_ff[0];
            integ_sel  = integ_ff[0];
            gains_sel  = roll_gains;
         end
      endcase
   end

   assign kp = gains_sel[GAIN_W-1:0];
   assign ki = gains_sel[2*GAIN_W-1:GAIN_W];
   assign kd = gains_sel[3*GAIN_W-1:2*GAIN_W];

   assign err_in  = {target_sel[DATA_W-1], target_sel} - {rate_sel[DATA_W-1], rate_sel};
   assign diff_in = {err_in[ERR_W-1], err_in} - {prev_sel[ERR_W-1], prev_sel};
   assign err_x   = {err_in[ERR_W-1], err_in};

   always_comb begin
      if (err_x < -UNITY) begin
         perr_x = -UNITY;
      end else if (err_x > UNITY) begin
         perr_x = UNITY;
      end else begin
         perr_x = err_x;
      end
   end

   // one shared 25x27 multiplier; wide operands go through in two halves
   always_comb begin
      case (cmd.op)
         OP_INT: begin
            mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step_time};
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         OP_DER: begin
            mul_a = inverse_step_time;
            mul_b = {{(MUL_B_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
         end
         OP_KP: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, kp};
            mul_b = {{(MUL_B_W-PERR_W){perr_ff[PERR_W-1]}}, perr_ff};
         end
         OP_KI_LO: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, ki};
            mul_b = {{(MUL_B_W-SPLIT){1'b0}}, integ_sel[SPLIT-1:0]};
         end
         OP_KI_HI: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, ki};
            mul_b = {{(MUL_B_W-INTEG_W+SPLIT){integ_sel[INTEG_W-1]}},
                     integ_sel[INTEG_W-1:SPLIT]};
         end
         OP_KD_LO: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, kd};
            mul_b = {{(MUL_B_W-SPLIT){1'b0}}, deriv_ff[SPLIT-1:0]};
         end
         OP_KD_HI: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, kd};
            mul_b = {{(MUL_B_W-DERIV_W+SPLIT){deriv_ff[DERIV_W-1]}},
                     deriv_ff[DERIV_W-1:SPLIT]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = $signed({1'b0, mul_a}) * mul_b;

   assign integ_sum = {integ_sel[INTEG_W-1], integ_sel}
                    + {{(INTEG_W+1-PROD_W+DT_FRAC){prod_ff[PROD_W-1]}},
                       prod_ff[PROD_W-1:DT_FRAC]};

   always_comb begin
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   always_comb begin
      case (cmd.op) inside
         OP_KI_HI, OP_KD_HI: addend = {prod_ff[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}};
         default:            addend = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      endcase
   end

   assign thr_x   = {{(MIX_W-DATA_W){1'b0}}, thr_ff};
   assign roll_x  = {{(MIX_W-PID_W){pid_ff[0][PID_W-1]}}, pid_ff[0]};
   assign pitch_x = {{(MIX_W-PID_W){pid_ff[1][PID_W-1]}}, pid_ff[1]};
   assign yaw_x   = {{(MIX_W-PID_W){pid_ff[2][PID_W-1]}}, pid_ff[2]};
   assign mix1    = thr_x - roll_x + pitch_x + yaw_x;
   assign mix2    = thr_x - roll_x - pitch_x - yaw_x;
   assign mix3    = thr_x + roll_x - pitch_x + yaw_x;
   assign mix4    = thr_x + roll_x + pitch_x - yaw_x;

   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         rate_ff[0]   <= req_tdata[1*DATA_W-1:0*DATA_W];
         rate_ff[1]   <= req_tdata[2*DATA_W-1:1*DATA_W];
         rate_ff[2]   <= req_tdata[3*DATA_W-1:2*DATA_W];
         target_ff[0] <= req_tdata[4*DATA_W-1:3*DATA_W];
         target_ff[1] <= req_tdata[5*DATA_W-1:4*DATA_W];
         target_ff[2] <= req_tdata[6*DATA_W-1:5*DATA_W];
         thr_ff       <= req_tdata[7*DATA_W-1:6*DATA_W];
      end
      if (cmd.err_en) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
         perr_ff <= perr_x[PERR_W-1:0];
         acc_ff  <= '0;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.use_en) begin
         case (cmd.op)
            OP_INT:  ;
            OP_DER:  deriv_ff <= prod_ff[DERIV_W+INV_FRAC-1:INV_FRAC];
            default: acc_ff   <= acc_ff + addend;
         endcase
      end
      if (cmd.pid_en) begin
         case (cmd.axis)
            AXIS_PITCH: pid_ff[1] <= acc_ff[ACC_W-1:GAIN_FRAC];
            AXIS_YAW:   pid_ff[2] <= acc_ff[ACC_W-1:GAIN_FRAC];
            default:    pid_ff[0] <= acc_ff[ACC_W-1:GAIN_FRAC];
         endcase
      end
      if (cmd.mix_en) begin
         rsp_data_ff <= {motor_clamp(mix4, motor_min, motor_max),
                         motor_clamp(mix3, motor_min, motor_max),
                         motor_clamp(mix2, motor_min, motor_max),
                         motor_clamp(mix1, motor_min, motor_max)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            prev_ff[i]  <= '0;
            integ_ff[i] <= '0;
         end
      end else begin
         if (cmd.err_en) begin
            case (cmd.axis)
               AXIS_PITCH: prev_ff[1] <= err_in;
               AXIS_YAW:   prev_ff[2] <= err_in;
               default:    prev_ff[0] <= err_in;
            endcase
         end
         if (cmd.use_en && cmd.op == OP_INT) begin
            case (cmd.axis)
               AXIS_PITCH: integ_ff[1] <= integ_in;
               AXIS_YAW:   integ_ff[2] <= integ_in;
               default:    integ_ff[0] <= integ_in;
            endcase
         end
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

@@ rtl/quad_rate_pid_motor_mixer.sv @@
// channel | direction | handshake                 | payload
// req     | in        | req_tvalid / req_tready   | req_tdata: rates, targets, throttle
// rsp     | out       | rsp_tvalid / rsp_tready   | rsp_tdata: four motor speeds
// csr     | in        | csr_valid / csr_ready     | csr_index, csr_data
//
// The block takes a new item only when it is idle, after the last item has
// left its mix step. Per axis: an error step, seven multiply/accumulate
// ops, each a multiply step and a use step on the one shared 25x27
// multiplier, then a PID step; then a mix step.
// Reset clears the integrals, previous errors and output valid, and loads
// register defaults. A result waiting in the output register holds the
// block in its mix step, but a new item can be taken and run up to that step while it waits.
module quad_rate_pid_motor_mixer import qrpm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // roll_rate, pitch_rate, yaw_rate, roll_target, pitch_target, yaw_target, throttle
   input  logic [NUM_IN*DATA_W-1:0]    req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // motor_one, motor_two, motor_three, motor_four
   output logic [NUM_OUT*DATA_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [GAINS_W-1:0]          csr_data
);

   logic [GAINS_W-1:0] roll_gains_ff;
   logic [GAINS_W-1:0] pitch_gains_ff;
   logic [GAINS_W-1:0] yaw_gains_ff;
   logic [STEP_W-1:0]  step_time_ff;
   logic [DATA_W-1:0]  inv_step_ff;
   logic [DATA_W-1:0]  motor_min_ff;
   logic [DATA_W-1:0]  motor_max_ff;
   cmd_type            cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_gains_ff  <= '0;
         pitch_gains_ff <= '0;
         yaw_gains_ff   <= '0;
         step_time_ff   <= STEP_TIME_RST;
         inv_step_ff    <= INV_STEP_RST;
         motor_min_ff   <= MOTOR_MIN_RST;
         motor_max_ff   <= MOTOR_MAX_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROLL_GAINS:  roll_gains_ff  <= csr_data;
            CSR_PITCH_GAINS: pitch_gains_ff <= csr_data;
            CSR_YAW_GAINS:   yaw_gains_ff   <= csr_data;
            CSR_STEP_TIME:   step_time_ff   <= csr_data[STEP_W-1:0];
            CSR_INV_STEP:    inv_step_ff    <= csr_data[DATA_W-1:0];
            CSR_MOTOR_MIN:   motor_min_ff   <= csr_data[DATA_W-1:0];
            CSR_MOTOR_MAX:   motor_max_ff   <= csr_data[DATA_W-1:0];
            default:         ;
         endcase
      end
   end

   qrpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   qrpm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_tdata         (req_tdata),
      .roll_gains        (roll_gains_ff),
      .pitch_gains       (pitch_gains_ff),
      .yaw_gains         (yaw_gains_ff),
      .step_time         (step_time_ff),
      .inverse_step_time (inv_step_ff),
      .motor_min         (motor_min_ff),
      .motor_max         (motor_max_ff),
      .rsp_data          (rsp_tdata)
   );

endmodule
